// File: hdl/dab_plus_firecode_frame_gate_defines.svh
// assertion macros for the superframe firecode gate checker
// used by dpfg_checker.sv, no other dependencies
`ifndef DAB_PLUS_FIRECODE_FRAME_GATE_DEFINES_SVH
`define DAB_PLUS_FIRECODE_FRAME_GATE_DEFINES_SVH

// implication in the same cycle, quiet during reset
`define DPFG_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication in the next cycle, quiet during reset
`define DPFG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// condition required in the cycle after reset is seen
`define DPFG_ASSERT_RESET(label, cons, msg) \
   label: assert property (@(posedge clock) reset |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/dpfg_pkg.sv
// shared constants, types and the firecode crc step for the frame gate
// no dependencies
`default_nettype none

package dpfg_pkg;

   // header geometry
   localparam int unsigned HEADER_BYTES = 12;
   localparam int unsigned CNT_W        = $clog2(HEADER_BYTES + 1);
   localparam int unsigned IDX_W        = $clog2(HEADER_BYTES);

   // firecode crc
   localparam logic [15:0] FC_POLY = 16'h782F;

   // reset value of the extra frame count register
   localparam logic [3:0] EXTRA_FRAMES_RESET = 4'd4;

   // controller to datapath commands
   typedef struct packed {
      logic             accept;
      logic             load_pass;
      logic             load_hdr;
      logic [IDX_W-1:0] hdr_idx;
   } cmd_type;

   // datapath to controller status for the byte on the input
   typedef struct packed {
      logic hdr_hit;
      logic pass_hit;
   } status_type;

   // one byte through the crc, msb first
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ FC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// File: hdl/dpfg_datapath.sv
// datapath: byte counter, firecode and crc registers, header store, output payload
// depends on dpfg_pkg
`default_nettype none

module dpfg_datapath (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_sync_flag,
   input  wire logic                 csr_wr_en,
   input  wire logic [3:0]           csr_wr_data,
   input  wire dpfg_pkg::cmd_type    cmd,
   output dpfg_pkg::status_type      status,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_frame_start,
   output logic                      rsp_last
);

   logic [3:0]                 extra_frames_ff;
   logic [dpfg_pkg::CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [15:0]                received_code_ff, received_code_in;
   logic [15:0]                computed_code_ff, computed_code_in;
   logic                       check_passed_ff, check_passed_in;
   logic [3:0]                 frames_left_ff, frames_left_in;
   logic [7:0]                 header_store_ff [dpfg_pkg::HEADER_BYTES];
   logic [7:0]                 out_byte_ff, out_byte_in;
   logic                       frame_start_ff, frame_start_in;
   logic                       last_ff, last_in;

   logic                       keep_gate;
   logic                       restart;
   logic [dpfg_pkg::CNT_W-1:0] eff_count;
   logic [15:0]                eff_crc;
   logic                       eff_passed;
   logic [3:0]                 eff_frames;
   logic                       in_header;
   logic                       hdr_hit;

   // sync handling and header check for the byte on the input
   always_comb begin
      keep_gate  = check_passed_ff && (frames_left_ff != 4'd0);
      restart    = req_sync_flag && !keep_gate;
      eff_count  = restart ? '0 : byte_count_ff;
      eff_crc    = restart ? 16'h0000 : computed_code_ff;
      eff_passed = restart ? 1'b0 : check_passed_ff;
      eff_frames = (req_sync_flag && keep_gate) ? (frames_left_ff - 4'd1) : frames_left_ff;
      in_header  = eff_count < dpfg_pkg::CNT_W'(dpfg_pkg::HEADER_BYTES);
      hdr_hit    = in_header
                && (eff_count == dpfg_pkg::CNT_W'(dpfg_pkg::HEADER_BYTES - 1))
                && (eff_crc == received_code_ff);
      status.hdr_hit  = hdr_hit;
      status.pass_hit = !in_header && eff_passed;
   end

   // next state of the gate on an accepted transaction
   always_comb begin
      byte_count_in    = eff_count;
      received_code_in = received_code_ff;
      computed_code_in = eff_crc;
      check_passed_in  = eff_passed;
      frames_left_in   = eff_frames;
      if (in_header) begin
         if (eff_count < dpfg_pkg::CNT_W'(2)) begin
            received_code_in = {received_code_ff[7:0], req_data_byte};
         end else if (eff_count < dpfg_pkg::CNT_W'(dpfg_pkg::HEADER_BYTES - 1)) begin
            computed_code_in = dpfg_pkg::crc_byte(eff_crc, req_data_byte);
         end
         if (hdr_hit) begin
            check_passed_in = 1'b1;
            frames_left_in  = extra_frames_ff;
         end
         byte_count_in = eff_count + dpfg_pkg::CNT_W'(1);
      end
   end

   // output payload selection
   always_comb begin
      out_byte_in    = out_byte_ff;
      frame_start_in = frame_start_ff;
      last_in        = last_ff;
      if (cmd.load_pass) begin
         out_byte_in    = req_data_byte;
         frame_start_in = 1'b0;
         last_in        = 1'b1;
      end else if (cmd.load_hdr) begin
         out_byte_in    = header_store_ff[cmd.hdr_idx];
         frame_start_in = cmd.hdr_idx == '0;
         last_in        = cmd.hdr_idx == dpfg_pkg::IDX_W'(dpfg_pkg::HEADER_BYTES - 1);
      end
   end

   // gate state and configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         extra_frames_ff  <= dpfg_pkg::EXTRA_FRAMES_RESET;
         byte_count_ff    <= '0;
         received_code_ff <= 16'h0000;
         computed_code_ff <= 16'h0000;
         check_passed_ff  <= 1'b0;
         frames_left_ff   <= 4'd0;
      end else begin
         if (csr_wr_en) begin
            extra_frames_ff <= csr_wr_data;
         end
         if (cmd.accept) begin
            byte_count_ff    <= byte_count_in;
            received_code_ff <= received_code_in;
            computed_code_ff <= computed_code_in;
            check_passed_ff  <= check_passed_in;
            frames_left_ff   <= frames_left_in;
         end
      end
   end

   // header store and output payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.accept && in_header) begin
         header_store_ff[eff_count[dpfg_pkg::IDX_W-1:0]] <= req_data_byte;
      end
      out_byte_ff    <= out_byte_in;
      frame_start_ff <= frame_start_in;
      last_ff        <= last_in;
   end

   assign rsp_out_byte    = out_byte_ff;
   assign rsp_frame_start = frame_start_ff;
   assign rsp_last        = last_ff;

endmodule

`default_nettype wire

// File: hdl/dpfg_controller.sv
// controller: input handshake, header burst sequencing, output valid
// depends on dpfg_pkg
`default_nettype none

module dpfg_controller (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   input  wire dpfg_pkg::status_type    status,
   output dpfg_pkg::cmd_type            cmd
);

   typedef enum logic [0:0] {
      ST_RUN,
      ST_BURST
   } state_type;

   state_type                  state_ff, state_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dpfg_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                       out_free;

   // next state, commands and output valid
   always_comb begin
      out_free      = !rsp_valid_ff || rsp_ready;
      state_in      = state_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      req_ready     = 1'b0;
      cmd.accept    = 1'b0;
      cmd.load_pass = 1'b0;
      cmd.load_hdr  = 1'b0;
      cmd.hdr_idx   = idx_ff;
      unique case (state_ff)
         ST_RUN: begin
            req_ready  = out_free;
            cmd.accept = req_valid && out_free;
            if (cmd.accept && status.pass_hit) begin
               cmd.load_pass = 1'b1;
               rsp_valid_in  = 1'b1;
            end else if (cmd.accept && status.hdr_hit) begin
               state_in = ST_BURST;
               idx_in   = '0;
            end
         end
         ST_BURST: begin
            if (out_free) begin
               cmd.load_hdr = 1'b1;
               rsp_valid_in = 1'b1;
               idx_in       = idx_ff + dpfg_pkg::IDX_W'(1);
               if (idx_ff == dpfg_pkg::IDX_W'(dpfg_pkg::HEADER_BYTES - 1)) begin
                  state_in = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

// File: hdl/dab_plus_firecode_frame_gate.sv
// Superframe firecode gate. Bytes enter one per cycle while the output register is free:
// during header collection, failed-check dropping and passthrough the block sustains one
// transaction per cycle. When the 12th header byte (HEADER_BYTES) completes a matching
// firecode, the stored header is replayed from the header store one entry per cycle
// through the single output register while it is free, with req_ready held low meanwhile.
// Throughput is set by that output register. No clearing pass is run after reset. The
// user must write extra_frames through csr_wr_en/csr_wr_data while idle; not enforced.
// depends on dpfg_pkg, dpfg_controller, dpfg_datapath
`default_nettype none

module dab_plus_firecode_frame_gate (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_sync_flag,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_frame_start,
   output logic            rsp_last,
   input  wire logic       csr_wr_en,
   input  wire logic [3:0] csr_wr_data
);

   dpfg_pkg::cmd_type    cmd;
   dpfg_pkg::status_type status;

   // handshake and burst sequencing
   dpfg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // gate state, header store and output payload
   dpfg_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_data_byte   (req_data_byte),
      .req_sync_flag   (req_sync_flag),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .cmd             (cmd),
      .status          (status),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_frame_start (rsp_frame_start),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

// File: hdl/dpfg_checker.sv
// port-level checker for the frame gate, bound to the top level
// depends on dab_plus_firecode_frame_gate_defines.svh
`default_nettype none

`include "dab_plus_firecode_frame_gate_defines.svh"

module dpfg_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_frame_start,
   input wire logic       rsp_last
);

   // a stalled result transaction holds its payload
   `DPFG_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_out_byte) && $stable(rsp_frame_start) && $stable(rsp_last), "stalled result changed")

   // a header burst start is never its own last byte
   `DPFG_ASSERT_SAME(a_start_not_last, rsp_valid && rsp_frame_start, !rsp_last, "frame start marked last")

   // input is held off while a header burst is in flight
   `DPFG_ASSERT_SAME(a_burst_stalls_in, rsp_valid && rsp_frame_start, !req_ready, "input accepted during header burst")

   // header bytes follow back to back once the first is taken
   `DPFG_ASSERT_NEXT(a_burst_dense, rsp_valid && rsp_ready && rsp_frame_start, rsp_valid && !rsp_frame_start, "gap in header burst")

   // no result right after reset
   `DPFG_ASSERT_RESET(a_reset_idle, !rsp_valid, "result valid after reset")

endmodule

bind dab_plus_firecode_frame_gate dpfg_checker u_dpfg_checker (.*);

`default_nettype wire
